// ===== src/gsa_pkg.sv =====
// Shared constants, types and table functions for the gas sensor linearizer.
`default_nettype none
package gsa_pkg;

    localparam int ADC_BITS      = 12;
    localparam int LUT_ADDR_BITS = 6;
    localparam int LUT_SIZE      = (1 << LUT_ADDR_BITS) + 1;
    localparam int LUT_IDX_W     = LUT_ADDR_BITS + 1;

    localparam longint unsigned ADC_FULL = (64'd1 << ADC_BITS) - 64'd1;

    // Rs = 10000*(50*FS - 33*adc) / (33*adc)
    localparam int OHM_NUM_W = $clog2(64'd500000 * ADC_FULL + 64'd1);
    localparam int OHM_DEN_W = $clog2(64'd33 * ADC_FULL + 64'd1);

    localparam int OHMS_W  = 25;
    localparam int RATIO_W = 32;
    localparam int PPM_W   = 24;
    localparam int RO_W    = 20;
    localparam int COEF_W  = 16;
    localparam int CFG_W   = 20;
    localparam int LOG_W   = 22;
    localparam int NUM_W   = 24;
    localparam int E_W     = 36;
    localparam int IP_W    = E_W - 16;

    localparam int LOG_TAB_W = 17;
    localparam int EXP_TAB_W = 18;

    localparam logic [OHMS_W-1:0]  OHMS_MAX  = '1;
    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
    localparam logic [PPM_W-1:0]   PPM_MAX   = '1;

    localparam int LOG2_TEN_Q16 = 217706;

    typedef enum logic [1:0] {
        REG_CLEAN_AIR = 2'd0,
        REG_SLOPE     = 2'd1,
        REG_INTERCEPT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                open;
        logic [OHMS_W-1:0]   ohms;
        logic [RATIO_W-1:0]  ratio;
    } side_t;

    function automatic longint unsigned isqrt64(longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bitv;
        v    = v_in;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // log2(1 + i/2^L) in Q16, truncated
    function automatic logic [LOG_TAB_W-1:0] log_tab_val(int i);
        longint unsigned x;
        longint unsigned acc;
        x   = 0;
        acc = 0;
        if (i == (1 << LUT_ADDR_BITS)) return LOG_TAB_W'(65536);
        x = (64'd1 << 30) + ((longint'(i) << 30) >> LUT_ADDR_BITS);
        for (int k = 0; k < 16; k++) begin
            x   = (x * x) >> 30;
            acc = acc << 1;
            if (x >= (64'd2 << 30)) begin
                acc = acc | 64'd1;
                x   = x >> 1;
            end
        end
        return LOG_TAB_W'(acc);
    endfunction

    // 2^(i/2^L) in Q16, rounded
    function automatic logic [EXP_TAB_W-1:0] exp_tab_val(int i);
        longint unsigned roots [LUT_ADDR_BITS+1];
        longint unsigned p;
        p = 64'd1 << 30;
        if (i == (1 << LUT_ADDR_BITS)) return EXP_TAB_W'(131072);
        roots[0] = 64'd1 << 31;
        for (int k = 1; k <= LUT_ADDR_BITS; k++) roots[k] = isqrt64(roots[k-1] << 30);
        for (int k = 0; k < LUT_ADDR_BITS; k++)
            if (((i >> k) & 1) != 0) p = (p * roots[LUT_ADDR_BITS-k]) >> 30;
        return EXP_TAB_W'((p + (64'd1 << 13)) >> 14);
    endfunction

endpackage
`default_nettype wire

// ===== src/gsa_ohms.sv =====
// Sensor resistance: divider front end and pipelined restoring divider.
`default_nettype none
module gsa_ohms (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [gsa_pkg::ADC_BITS-1:0]  adc,
    output logic                          out_valid,
    output logic [gsa_pkg::OHMS_W-1:0]    ohms,
    output logic                          open_flag
);
    localparam int N  = gsa_pkg::OHM_NUM_W;
    localparam int DW = gsa_pkg::OHM_DEN_W;

    logic          v_reg    [N+1];
    logic [N-1:0]  qd_reg   [N+1];
    logic [DW-1:0] r_reg    [N+1];
    logic [DW-1:0] den_reg  [N+1];
    logic          open_reg [N+1];
    logic [N-1:0]  qd_next  [N];
    logic [DW-1:0] r_next   [N];

    logic                       out_v_reg;
    logic [gsa_pkg::OHMS_W-1:0] ohms_reg;
    logic                       open_out_reg;

    logic [N-1:0]  num_in;
    logic [DW-1:0] den_in;
    logic          open_in;

    always_comb
    begin
        den_in  = DW'(64'd33 * 64'(adc));
        num_in  = N'(64'd10000 * (64'd50 * gsa_pkg::ADC_FULL - 64'd33 * 64'(adc)));
        open_in = (64'd3300 * 64'(adc)) < gsa_pkg::ADC_FULL;
    end

    always_comb
    begin
        logic [DW:0] rr;
        logic        take;
        for (int k = 0; k < N; k++) begin
            rr         = {r_reg[k], qd_reg[k][N-1]};
            take       = rr >= {1'b0, den_reg[k]};
            r_next[k]  = take ? DW'(rr - {1'b0, den_reg[k]}) : rr[DW-1:0];
            qd_next[k] = {qd_reg[k][N-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k <= N; k++) v_reg[k] <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < N; k++) v_reg[k+1] <= v_reg[k];
            out_v_reg <= v_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            qd_reg[0]   <= num_in;
            r_reg[0]    <= '0;
            den_reg[0]  <= den_in;
            open_reg[0] <= open_in;
            for (int k = 0; k < N; k++) begin
                qd_reg[k+1]   <= qd_next[k];
                r_reg[k+1]    <= r_next[k];
                den_reg[k+1]  <= den_reg[k];
                open_reg[k+1] <= open_reg[k];
            end
            open_out_reg <= open_reg[N];
            if (open_reg[N] || (64'(qd_reg[N]) > 64'(gsa_pkg::OHMS_MAX)))
                ohms_reg <= gsa_pkg::OHMS_MAX;
            else
                ohms_reg <= gsa_pkg::OHMS_W'(qd_reg[N]);
        end
    end

    assign out_valid = out_v_reg;
    assign ohms      = ohms_reg;
    assign open_flag = open_out_reg;
endmodule
`default_nettype wire

// ===== src/gsa_ratio.sv =====
// Ratio Rs/Ro in Q20.12 through a pipelined restoring divider.
`default_nettype none
module gsa_ratio (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [gsa_pkg::OHMS_W-1:0]  ohms,
    input  logic                        open_flag,
    input  logic [gsa_pkg::RO_W-1:0]    ro,
    output logic                        out_valid,
    output gsa_pkg::side_t              side
);
    localparam int N  = gsa_pkg::OHMS_W + 12;
    localparam int DW = gsa_pkg::RO_W;

    logic                       v_reg    [N+1];
    logic [N-1:0]               qd_reg   [N+1];
    logic [DW-1:0]              r_reg    [N+1];
    logic [DW-1:0]              den_reg  [N+1];
    logic                       zero_reg [N+1];
    logic                       open_reg [N+1];
    logic [gsa_pkg::OHMS_W-1:0] ohms_reg [N+1];
    logic [N-1:0]               qd_next  [N];
    logic [DW-1:0]              r_next   [N];

    logic           out_v_reg;
    gsa_pkg::side_t side_reg;

    always_comb
    begin
        logic [DW:0] rr;
        logic        take;
        for (int k = 0; k < N; k++) begin
            rr         = {r_reg[k], qd_reg[k][N-1]};
            take       = rr >= {1'b0, den_reg[k]};
            r_next[k]  = take ? DW'(rr - {1'b0, den_reg[k]}) : rr[DW-1:0];
            qd_next[k] = {qd_reg[k][N-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k <= N; k++) v_reg[k] <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < N; k++) v_reg[k+1] <= v_reg[k];
            out_v_reg <= v_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            qd_reg[0]   <= {ohms, 12'b0};
            r_reg[0]    <= '0;
            den_reg[0]  <= ro;
            zero_reg[0] <= (ro == '0);
            open_reg[0] <= open_flag;
            ohms_reg[0] <= ohms;
            for (int k = 0; k < N; k++) begin
                qd_reg[k+1]   <= qd_next[k];
                r_reg[k+1]    <= r_next[k];
                den_reg[k+1]  <= den_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                open_reg[k+1] <= open_reg[k];
                ohms_reg[k+1] <= ohms_reg[k];
            end
            side_reg.open <= open_reg[N];
            side_reg.ohms <= ohms_reg[N];
            if (zero_reg[N] || open_reg[N] || (64'(qd_reg[N]) > 64'(gsa_pkg::RATIO_MAX)))
                side_reg.ratio <= gsa_pkg::RATIO_MAX;
            else
                side_reg.ratio <= gsa_pkg::RATIO_W'(qd_reg[N]);
        end
    end

    assign out_valid = out_v_reg;
    assign side      = side_reg;
endmodule
`default_nettype wire

// ===== src/gsa_log2.sv =====
// Table-based log2 of the Q20.12 ratio, result Q16, five stages.
`default_nettype none
module gsa_log2 (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  gsa_pkg::side_t                    side_in,
    output logic                              out_valid,
    output gsa_pkg::side_t                    side_out,
    output logic signed [gsa_pkg::LOG_W-1:0]  log2_q16
);
    localparam int L  = gsa_pkg::LUT_ADDR_BITS;
    localparam int IW = gsa_pkg::LUT_IDX_W;
    localparam int TW = gsa_pkg::LOG_TAB_W;

    logic [TW-1:0] log_tab [gsa_pkg::LUT_SIZE];

    for (genvar g = 0; g < gsa_pkg::LUT_SIZE; g++) begin : g_tab
        assign log_tab[g] = gsa_pkg::log_tab_val(g);
    end

    logic           v_reg [5];
    gsa_pkg::side_t s_reg [5];

    logic [4:0]    p1_reg, p2_reg, p3_reg, p4_reg;
    logic [L-1:0]  idx2_reg;
    logic [15:0]   t2_reg, t3_reg;
    logic [TW-1:0] lo3_reg, diff3_reg, lo4_reg, prod4_reg;
    logic signed [gsa_pkg::LOG_W-1:0] log5_reg;

    logic [4:0]  p_enc;
    logic [31:0] norm;

    // leading one of the ratio
    always_comb
    begin
        p_enc = '0;
        for (int b = 0; b < 32; b++)
            if (side_in.ratio[b]) p_enc = 5'(b);
    end

    assign norm = s_reg[0].ratio << (~p1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k < 5; k++) v_reg[k] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < 4; k++) v_reg[k+1] <= v_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s_reg[0] <= side_in;
            for (int k = 0; k < 4; k++) s_reg[k+1] <= s_reg[k];
            p1_reg <= p_enc;

            p2_reg   <= p1_reg;
            idx2_reg <= norm[30 -: L];
            t2_reg   <= norm[30-L -: 16];

            p3_reg    <= p2_reg;
            t3_reg    <= t2_reg;
            lo3_reg   <= log_tab[IW'(idx2_reg)];
            diff3_reg <= log_tab[IW'(idx2_reg) + IW'(1)] - log_tab[IW'(idx2_reg)];

            p4_reg    <= p3_reg;
            lo4_reg   <= lo3_reg;
            prod4_reg <= TW'((33'(diff3_reg) * 33'(t3_reg)) >> 16);

            log5_reg <= gsa_pkg::LOG_W'((int'(p4_reg) - 12) * 65536
                                        + int'(lo4_reg) + int'(prod4_reg));
        end
    end

    assign out_valid = v_reg[4];
    assign side_out  = s_reg[4];
    assign log2_q16  = log5_reg;
endmodule
`default_nettype wire

// ===== src/gsa_curve.sv =====
// Curve exponent e = (log2(ratio) - b*log2(10)) * 4096 / m, pipelined divider.
`default_nettype none
module gsa_curve (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  gsa_pkg::side_t                     side_in,
    input  logic signed [gsa_pkg::LOG_W-1:0]   log2_q16,
    input  logic signed [gsa_pkg::COEF_W-1:0]  slope,
    input  logic signed [gsa_pkg::COEF_W-1:0]  intercept,
    output logic                               out_valid,
    output gsa_pkg::side_t                     side_out,
    output logic                               ppm_en,
    output logic signed [gsa_pkg::E_W-1:0]     expo
);
    localparam int NW = gsa_pkg::NUM_W;
    localparam int N  = NW - 1 + 12;
    localparam int DW = gsa_pkg::COEF_W;

    logic                 v_reg    [N+1];
    logic [N-1:0]         qd_reg   [N+1];
    logic [DW-1:0]        r_reg    [N+1];
    logic [DW-1:0]        den_reg  [N+1];
    logic                 neg_reg  [N+1];
    logic                 pen_reg  [N+1];
    gsa_pkg::side_t       s_reg    [N+1];
    logic [N-1:0]         qd_next  [N];
    logic [DW-1:0]        r_next   [N];

    logic                           out_v_reg;
    gsa_pkg::side_t                 s_out_reg;
    logic                           pen_out_reg;
    logic signed [gsa_pkg::E_W-1:0] e_reg;

    // b*log2(10) in Q28, follows the intercept register
    logic signed [34:0]   bl_prod_reg;
    logic signed [NW-1:0] bl;
    logic signed [NW-1:0] num;
    logic [NW-2:0]        mag;
    logic [DW-1:0]        slope_mag;

    always_ff @(posedge clk)
    begin
        bl_prod_reg <= 35'(intercept) * 35'sd217706;
    end

    always_comb
    begin
        bl        = NW'(bl_prod_reg >>> 12);
        num       = NW'(log2_q16) - bl;
        mag       = num[NW-1] ? (NW-1)'(-num) : num[NW-2:0];
        slope_mag = slope[DW-1] ? DW'(-slope) : slope;
    end

    always_comb
    begin
        logic [DW:0] rr;
        logic        take;
        for (int k = 0; k < N; k++) begin
            rr         = {r_reg[k], qd_reg[k][N-1]};
            take       = rr >= {1'b0, den_reg[k]};
            r_next[k]  = take ? DW'(rr - {1'b0, den_reg[k]}) : rr[DW-1:0];
            qd_next[k] = {qd_reg[k][N-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k <= N; k++) v_reg[k] <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < N; k++) v_reg[k+1] <= v_reg[k];
            out_v_reg <= v_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            qd_reg[0]  <= {mag, 12'b0};
            r_reg[0]   <= '0;
            den_reg[0] <= slope_mag;
            neg_reg[0] <= num[NW-1] ^ slope[DW-1];
            pen_reg[0] <= (side_in.ratio != '0) && (slope != '0) && !side_in.open;
            s_reg[0]   <= side_in;
            for (int k = 0; k < N; k++) begin
                qd_reg[k+1]  <= qd_next[k];
                r_reg[k+1]   <= r_next[k];
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                pen_reg[k+1] <= pen_reg[k];
                s_reg[k+1]   <= s_reg[k];
            end
            s_out_reg   <= s_reg[N];
            pen_out_reg <= pen_reg[N];
            e_reg       <= neg_reg[N] ? -$signed({1'b0, qd_reg[N]})
                                      : $signed({1'b0, qd_reg[N]});
        end
    end

    assign out_valid = out_v_reg;
    assign side_out  = s_out_reg;
    assign ppm_en    = pen_out_reg;
    assign expo      = e_reg;
endmodule
`default_nettype wire

// ===== src/gsa_exp2.sv =====
// Table-based 2^e scaled to Q16.8 with saturation, three stages.
`default_nettype none
module gsa_exp2 (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  gsa_pkg::side_t                    side_in,
    input  logic                              ppm_en,
    input  logic signed [gsa_pkg::E_W-1:0]    expo,
    output logic                              out_valid,
    output gsa_pkg::side_t                    side_out,
    output logic [gsa_pkg::PPM_W-1:0]         ppm
);
    localparam int L  = gsa_pkg::LUT_ADDR_BITS;
    localparam int IW = gsa_pkg::LUT_IDX_W;
    localparam int TW = gsa_pkg::EXP_TAB_W;
    localparam int RW = 16 - L;
    localparam int IPW = gsa_pkg::IP_W;

    logic [TW-1:0] exp_tab [gsa_pkg::LUT_SIZE];

    for (genvar g = 0; g < gsa_pkg::LUT_SIZE; g++) begin : g_tab
        assign exp_tab[g] = gsa_pkg::exp_tab_val(g);
    end

    logic           v_reg   [3];
    gsa_pkg::side_t s_reg   [3];
    logic           pen_reg [3];

    logic signed [IPW-1:0] ip1_reg, ip2_reg;
    logic [TW-1:0]         lo1_reg, diff1_reg, mant2_reg;
    logic [RW-1:0]         rem1_reg;
    logic [gsa_pkg::PPM_W-1:0] ppm_reg;

    logic [L-1:0]  idx;
    logic [gsa_pkg::PPM_W-1:0] scaled;
    logic [TW+8:0] up;
    logic [4:0]    dn;

    assign idx = expo[15 -: L];

    always_comb
    begin
        up = '0;
        dn = '0;
        if (ip2_reg >= IPW'(17)) begin
            scaled = gsa_pkg::PPM_MAX;
        end else if (ip2_reg >= IPW'(8)) begin
            up = (TW+9)'(mant2_reg) << (ip2_reg[3:0] - 4'd8);
            scaled = (up > (TW+9)'(gsa_pkg::PPM_MAX)) ? gsa_pkg::PPM_MAX
                                                      : gsa_pkg::PPM_W'(up);
        end else if (ip2_reg <= -IPW'(10)) begin
            scaled = '0;
        end else begin
            dn = 5'(8 - int'(ip2_reg));
            scaled = gsa_pkg::PPM_W'(mant2_reg >> dn);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k < 3; k++) v_reg[k] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < 2; k++) v_reg[k+1] <= v_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s_reg[0]   <= side_in;
            pen_reg[0] <= ppm_en;
            for (int k = 0; k < 2; k++) begin
                s_reg[k+1]   <= s_reg[k];
                pen_reg[k+1] <= pen_reg[k];
            end

            ip1_reg   <= expo[gsa_pkg::E_W-1:16];
            rem1_reg  <= expo[RW-1:0];
            lo1_reg   <= exp_tab[IW'(idx)];
            diff1_reg <= exp_tab[IW'(idx) + IW'(1)] - exp_tab[IW'(idx)];

            ip2_reg   <= ip1_reg;
            mant2_reg <= lo1_reg + TW'((32'(diff1_reg) * 32'(rem1_reg)) >> RW);

            ppm_reg <= pen_reg[1] ? scaled : '0;
        end
    end

    assign out_valid = v_reg[2];
    assign side_out  = s_reg[2];
    assign ppm       = ppm_reg;
endmodule
`default_nettype wire

// ===== src/gas_sensor_adc_to_ppm_top.sv =====
// Top level of the gas sensor ADC to ppm linearizer.
`default_nettype none
// One 12-bit sample in, one result out: sensor resistance (ohms), ratio to the
// clean-air resistance (Q20.12) and concentration (ppm, Q16.8), open flag in
// m_tuser. The datapath is one pipeline of 117 register stages at 12 bits
// (resistance divider 33, ratio divider 39, log2 5, curve divider 37, exp2 3),
// so a new sample is taken every cycle unless the output stalls. The three
// dividers retire one quotient bit per stage. The whole pipeline holds while a
// result waits on m_tready. Configuration writes take effect on the next
// sample; write them only while no sample is in flight.
module gas_sensor_adc_to_ppm_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] adc_raw
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [24:0] sensor_ohms, [56:25] ratio_q12, [80:57] ppm_q8
    output logic [0:0]  m_tuser,   // [0] open_flag
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    logic [gsa_pkg::RO_W-1:0]          ro_reg;
    logic signed [gsa_pkg::COEF_W-1:0] slope_reg;
    logic signed [gsa_pkg::COEF_W-1:0] icpt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ro_reg    <= gsa_pkg::RO_W'(10000);
            slope_reg <= -gsa_pkg::COEF_W'(2679);
            icpt_reg  <= gsa_pkg::COEF_W'(6959);
        end else if (cfg_wen) begin
            case (gsa_pkg::cfg_reg_t'(cfg_index))
                gsa_pkg::REG_CLEAN_AIR: ro_reg    <= cfg_data;
                gsa_pkg::REG_SLOPE:     slope_reg <= cfg_data[15:0];
                gsa_pkg::REG_INTERCEPT: icpt_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic v_ohms, v_ratio, v_log, v_curve, v_exp;
    logic [gsa_pkg::OHMS_W-1:0] ohms;
    logic open_o;
    gsa_pkg::side_t side_r, side_l, side_c, side_e;
    logic signed [gsa_pkg::LOG_W-1:0] log2_q16;
    logic signed [gsa_pkg::E_W-1:0]   expo;
    logic pen;
    logic [gsa_pkg::PPM_W-1:0] ppm;

    assign en       = !v_exp || m_tready;
    assign s_tready = en;

    gsa_ohms u_ohms (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_tvalid),
        .adc(s_tdata[gsa_pkg::ADC_BITS-1:0]),
        .out_valid(v_ohms), .ohms(ohms), .open_flag(open_o)
    );

    gsa_ratio u_ratio (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_ohms),
        .ohms(ohms), .open_flag(open_o), .ro(ro_reg),
        .out_valid(v_ratio), .side(side_r)
    );

    gsa_log2 u_log2 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_ratio),
        .side_in(side_r), .out_valid(v_log), .side_out(side_l), .log2_q16(log2_q16)
    );

    gsa_curve u_curve (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_log),
        .side_in(side_l), .log2_q16(log2_q16), .slope(slope_reg), .intercept(icpt_reg),
        .out_valid(v_curve), .side_out(side_c), .ppm_en(pen), .expo(expo)
    );

    gsa_exp2 u_exp2 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_curve),
        .side_in(side_c), .ppm_en(pen), .expo(expo),
        .out_valid(v_exp), .side_out(side_e), .ppm(ppm)
    );

    assign m_tvalid   = v_exp;
    assign m_tdata    = {7'b0, ppm, side_e.ratio, side_e.ohms};
    assign m_tuser[0] = side_e.open;

`ifndef SYNTH
    a_open_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[80:57] == 24'd0)
                                 && (m_tdata[24:0] == gsa_pkg::OHMS_MAX))
        else $error("open sample with non-saturated result");

    a_ppm_needs_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[80:57] != 24'd0) |-> (m_tdata[56:25] != 32'd0))
        else $error("nonzero ppm from zero ratio");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(side_e) && $stable(ppm))
        else $error("pipeline output moved during stall");
`endif
endmodule
`default_nettype wire

// ===== bench/tb_gas_sensor_adc_to_ppm_top.sv =====
// Self-checking testbench for the gas sensor ADC to ppm linearizer.
`default_nettype none
module tb_gas_sensor_adc_to_ppm_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH  = 117;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;
    localparam int LB          = gsa_pkg::LUT_ADDR_BITS;

    typedef struct {
        logic [gsa_pkg::OHMS_W-1:0]  ohms;
        logic [gsa_pkg::RATIO_W-1:0] ratio;
        logic [gsa_pkg::PPM_W-1:0]   ppm;
        logic                        open;
    } reading_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [87:0]       m_tdata;
    logic [0:0]        m_tuser;
    logic              cfg_wen;
    gsa_pkg::cfg_reg_t cfg_index;
    logic [19:0]       cfg_data;

    gas_sensor_adc_to_ppm_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // local copy of the settings and of the fractional tables
    longint    ro_ohms;
    int        slope_q12;
    int        icept_q12;
    longint    log_lut [gsa_pkg::LUT_SIZE];
    longint    exp_lut [gsa_pkg::LUT_SIZE];

    logic [11:0] sample_feed [$];
    reading_t    pending_readings [$];
    int          errs;
    int          stall_cycles;
    bit          burst_mode;
    int          hold_req_cnt;
    int          hold_ack_cnt;
    int          tx_gap;
    int          rx_gap;
    int          rx_hold_left;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v_in);
        longint unsigned v;
        longint unsigned root;
        longint unsigned probe;
        v     = v_in;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    task automatic fill_luts();
        longint unsigned roots [LB+1];
        longint unsigned x;
        longint unsigned acc;
        longint unsigned p;
        roots[0] = 64'd1 << 31;
        for (int k = 1; k <= LB; k++)
            roots[k] = int_sqrt(roots[k-1] << 30);
        for (int i = 0; i < (1 << LB); i++)
        begin
            // squaring method: one fraction bit per pass
            x   = (64'd1 << 30) + ((longint'(i) << 30) >> LB);
            acc = 0;
            for (int k = 0; k < 16; k++)
            begin
                x   = (x * x) >> 30;
                acc = acc << 1;
                if (x >= (64'd2 << 30))
                begin
                    acc = acc | 1;
                    x   = x >> 1;
                end
            end
            log_lut[i] = longint'(acc);
            p = 64'd1 << 30;
            for (int k = 0; k < LB; k++)
                if (((i >> k) & 1) != 0)
                    p = (p * roots[LB-k]) >> 30;
            exp_lut[i] = longint'((p + (64'd1 << 13)) >> 14);
        end
        log_lut[1 << LB] = 65536;
        exp_lut[1 << LB] = 131072;
    endtask

    function automatic longint log2_of_ratio(logic [31:0] r);
        int          lead;
        logic [31:0] frac;
        int          idx;
        longint      t;
        lead = 31;
        while (!r[lead]) lead--;
        frac = (r << (31 - lead)) & 32'h7FFF_FFFF;
        idx  = int'(frac >> (31 - LB));
        t    = longint'((frac & ((32'd1 << (31 - LB)) - 1)) >> (15 - LB));
        return longint'(lead - 12) * 65536 + log_lut[idx]
             + (((log_lut[idx+1] - log_lut[idx]) * t) >>> 16);
    endfunction

    function automatic logic [gsa_pkg::PPM_W-1:0] pow2_to_ppm(longint e);
        longint ip;
        longint f;
        int     idx;
        longint rem;
        longint mant;
        longint sh;
        longint v;
        ip   = e >>> 16;
        f    = e - ip * 65536;
        idx  = int'(f >>> (16 - LB));
        rem  = f & ((64'd1 << (16 - LB)) - 1);
        mant = exp_lut[idx] + (((exp_lut[idx+1] - exp_lut[idx]) * rem) >>> (16 - LB));
        sh   = ip - 8;
        if (sh >= 9)
            return gsa_pkg::PPM_MAX;
        if (sh >= 0)
        begin
            v = mant << sh;
            return (v > longint'(gsa_pkg::PPM_MAX)) ? gsa_pkg::PPM_MAX
                                                    : gsa_pkg::PPM_W'(v);
        end
        if (sh <= -40)
            return '0;
        return gsa_pkg::PPM_W'(mant >> (-sh));
    endfunction

    function automatic reading_t linearize(logic [11:0] adc);
        reading_t rd;
        longint   rs;
        longint   q;
        longint   bl;
        longint   e;
        longint   full;
        full    = longint'(gsa_pkg::ADC_FULL);
        rd.ppm  = '0;
        rd.open = 1'b0;
        if (3300 * longint'(adc) < full)
        begin
            rd.ohms  = gsa_pkg::OHMS_MAX;
            rd.ratio = gsa_pkg::RATIO_MAX;
            rd.open  = 1'b1;
            return rd;
        end
        rs = 10000 * (50 * full - 33 * longint'(adc)) / (33 * longint'(adc));
        if (rs > longint'(gsa_pkg::OHMS_MAX))
            rs = longint'(gsa_pkg::OHMS_MAX);
        rd.ohms = gsa_pkg::OHMS_W'(rs);
        if (ro_ohms == 0)
            rd.ratio = gsa_pkg::RATIO_MAX;
        else
        begin
            q        = (rs << 12) / ro_ohms;
            rd.ratio = (q > longint'(gsa_pkg::RATIO_MAX)) ? gsa_pkg::RATIO_MAX
                                                          : gsa_pkg::RATIO_W'(q);
        end
        if (rd.ratio != 0 && slope_q12 != 0)
        begin
            bl     = (longint'(icept_q12) * gsa_pkg::LOG2_TEN_Q16) >>> 12;
            e      = ((log2_of_ratio(rd.ratio) - bl) * 4096) / longint'(slope_q12);
            rd.ppm = pow2_to_ppm(e);
        end
        return rd;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            tx_gap   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                pending_readings.push_back(linearize(s_tdata[11:0]));
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap   <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (sample_feed.size() > 0)
                begin
                    s_tdata  <= {4'b0, sample_feed.pop_front()};
                    s_tvalid <= 1'b1;
                    tx_gap   <= burst_mode ? 0 : $urandom_range(0, 15);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            rx_gap       <= 0;
            rx_hold_left <= 0;
            hold_ack_cnt <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_readings.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected result: tdata=%h tuser=%b", m_tdata, m_tuser);
                end
                else
                begin
                    reading_t want;
                    want = pending_readings.pop_front();
                    if (m_tdata[24:0] !== want.ohms || m_tdata[56:25] !== want.ratio
                        || m_tdata[80:57] !== want.ppm || m_tuser[0] !== want.open)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display({"mismatch: ohms %0d/%0d ratio %0d/%0d ",
                                      "ppm %0d/%0d open %b/%b"},
                                     want.ohms, m_tdata[24:0], want.ratio, m_tdata[56:25],
                                     want.ppm, m_tdata[80:57], want.open, m_tuser[0]);
                    end
                end
                rx_gap <= burst_mode ? 0 : $urandom_range(0, 15);
            end
            if (hold_req_cnt != hold_ack_cnt)
            begin
                hold_ack_cnt <= hold_req_cnt;
                rx_hold_left <= LONG_HOLD;
                m_tready     <= 1'b0;
            end
            else if (rx_hold_left > 0)
            begin
                rx_hold_left <= rx_hold_left - 1;
                m_tready     <= 1'b0;
            end
            else if (rx_gap > 0 && !(m_tvalid && m_tready))
            begin
                rx_gap   <= rx_gap - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= (m_tvalid && m_tready && !burst_mode) ? 1'b0 : 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(gsa_pkg::cfg_reg_t idx, logic [19:0] val);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        case (idx)
            gsa_pkg::REG_CLEAN_AIR: ro_ohms   = longint'(val);
            gsa_pkg::REG_SLOPE:     slope_q12 = int'($signed(val[15:0]));
            default:                icept_q12 = int'($signed(val[15:0]));
        endcase
    endtask

    task automatic set_curve(longint ro, int m, int b);
        write_reg(gsa_pkg::REG_CLEAN_AIR, 20'(ro));
        write_reg(gsa_pkg::REG_SLOPE, 20'(m[15:0]));
        write_reg(gsa_pkg::REG_INTERCEPT, 20'(b[15:0]));
    endtask

    // drain: everything sent and every result back
    task automatic wait_drained();
        @(negedge clk);
        while (sample_feed.size() > 0 || s_tvalid || pending_readings.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            sample_feed.push_back(($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 40))
                                                              : 12'($urandom));
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wen      = 1'b0;
        cfg_index    = gsa_pkg::REG_CLEAN_AIR;
        cfg_data     = '0;
        errs         = 0;
        burst_mode   = 1'b0;
        hold_req_cnt = 0;
        stall_cycles = 0;
        ro_ohms      = 10000;
        slope_q12    = -2679;
        icept_q12    = 6959;
        fill_luts();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: open sensor, scale ends, all single bits
        sample_feed = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd4095, 12'd4094, 12'd2048,
                        12'd1241, 12'd100, 12'hAAA, 12'h555, 12'd1};
        for (int b = 0; b < 12; b++)
            sample_feed.push_back(12'(1 << b));
        wait_drained();

        // register extremes, zero Ro, zero and positive slope
        set_curve(100, -32768, -32768);
        sample_feed = '{12'd2, 12'd4095, 12'd1500, 12'd0};
        queue_random(60);
        wait_drained();
        set_curve(1048575, -1, 32767);
        queue_random(60);
        wait_drained();
        set_curve(0, 0, 0);
        sample_feed = '{12'd2, 12'd4095};
        queue_random(20);
        wait_drained();
        set_curve(0, -2679, 6959);
        queue_random(20);
        wait_drained();
        set_curve(1000000, 32767, -1);
        queue_random(40);
        wait_drained();

        // back-pressure: receiver holds off while the sender streams
        set_curve(10000, -2679, 6959);
        burst_mode = 1'b1;
        @(posedge clk);
        hold_req_cnt <= hold_req_cnt + 1;
        queue_random(250);
        wait_drained();
        burst_mode = 1'b0;

        for (int ph = 0; ph < 6; ph++)
        begin
            set_curve($urandom_range(100, 1000000), -int'($urandom_range(1, 32768)),
                      int'($urandom_range(0, 65535)) - 32768);
            burst_mode = (ph == 3);
            queue_random(65);
            wait_drained();
        end
        burst_mode = 1'b0;

        repeat (PIPE_DEPTH + 20) @(negedge clk);
        if (errs == 0 && pending_readings.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
src/gsa_pkg.sv
src/gsa_ohms.sv
src/gsa_ratio.sv
src/gsa_log2.sv
src/gsa_curve.sv
src/gsa_exp2.sv
src/gas_sensor_adc_to_ppm_top.sv
bench/tb_gas_sensor_adc_to_ppm_top.sv
